// ===== hdl/stpb_pkg.sv =====
`timescale 1ns / 1ps

package stpb_pkg;

  // field widths
  localparam int BIN_W   = 12;
  localparam int CNT_W   = 13;
  localparam int LEVEL_W = 16;
  localparam int TIME_W  = 32;
  localparam int FRAME_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // internal level width, headroom for floor and signal offsets
  localparam int INT_LW = 20;

  // sizing
  localparam int MAX_BINS        = 4096;
  localparam int LEVEL_FRAC_BITS = 4;
  localparam int ONE_DB          = 1 << LEVEL_FRAC_BITS;

  // pattern timing and shape
  localparam int RAMP_MS         = 10000;
  localparam int SWEEP_MS        = 8000;
  localparam int COMB_LINES      = 8;
  localparam int NOISE_SPREAD_DB = 12;
  localparam int FLOOR_DB        = 10;
  localparam int SIG_BACKOFF_DB  = 5;
  localparam int COMB_DROP_DB    = 10;
  localparam int CAL_BASE_DB     = -120;
  localparam int CAL_STEP_DB     = 20;
  localparam int CAL_LINES       = 4;

  // hash constants
  localparam logic [31:0] HASH_SEED_MUL = 32'd1000003;
  localparam logic [31:0] MIX_XOR       = 32'd61;
  localparam logic [31:0] MIX_MUL       = 32'h27d4eb2d;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_SELECT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_HALF_BINS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_HALF_BINS   = 3'd5;

  // pattern codes
  localparam logic [2:0] PAT_FLOOR = 3'd0;
  localparam logic [2:0] PAT_RAMP  = 3'd1;
  localparam logic [2:0] PAT_CAL   = 3'd2;
  localparam logic [2:0] PAT_SWEPT = 3'd3;
  localparam logic [2:0] PAT_TWO   = 3'd4;
  localparam logic [2:0] PAT_COMB  = 3'd5;
  localparam logic [2:0] PAT_NOISE = 3'd6;
  localparam logic [2:0] PAT_SPARE = 3'd7;

  // register reset values
  localparam logic [CNT_W-1:0]          RST_BIN_COUNT = 13'd1024;
  localparam logic signed [LEVEL_W-1:0] RST_MIN_LEVEL = -16'sd2240;
  localparam logic signed [LEVEL_W-1:0] RST_MAX_LEVEL = 16'sd0;

  typedef struct packed {
    logic [BIN_W-1:0]   bin_index;
    logic [TIME_W-1:0]  time_ms;
    logic [FRAME_W-1:0] frame_number;
  } req_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level;
    logic [BIN_W-1:0]          bin_echo;
    logic                      bin_valid;
  } res_t;

endpackage

// ===== hdl/stpb_divc.sv =====
`timescale 1ns / 1ps

// unsigned divide by a constant: reciprocal multiply, remainder, one correction
module stpb_divc #(
  parameter int IN_W = 32,
  parameter int DIV  = 10000,
  localparam logic [63:0] RECIP = (64'd1 << 32) / DIV,
  localparam int RW = $clog2(RECIP + 64'd1),
  localparam int QW = IN_W + RW - 32,
  localparam int DW = $clog2(DIV + 1)
) (
  input  logic            clk,
  input  logic [2:0]      en,
  input  logic [IN_W-1:0] x,
  output logic [QW-1:0]   q,
  output logic [DW-1:0]   r
);

  localparam logic [DW:0] DIV_R = (DW+1)'(DIV);

  logic [IN_W+RW-1:0] prod;
  logic [IN_W-1:0]    xa;
  logic [QW-1:0]      q0;
  logic [IN_W-1:0]    qd;
  logic [IN_W-1:0]    rdiff;
  logic [QW-1:0]      qb;
  logic [DW:0]        rb;

  // estimate, low by at most one
  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod <= x * RECIP[RW-1:0];
      xa   <= x;
    end
  end

  assign q0    = prod[32 +: QW];
  assign qd    = IN_W'(q0) * IN_W'(DIV);
  assign rdiff = xa - qd;

  // raw remainder, below twice the divisor
  always_ff @(posedge clk) begin
    if (en[1]) begin
      qb <= q0;
      rb <= rdiff[DW:0];
    end
  end

  // single correction step
  always_ff @(posedge clk) begin
    if (en[2]) begin
      if (rb >= DIV_R) begin
        q <= qb + QW'(1);
        r <= DW'(rb - DIV_R);
      end else begin
        q <= qb;
        r <= rb[DW-1:0];
      end
    end
  end

endmodule

// ===== hdl/spectrum_test_pattern_bin_core.sv =====
`timescale 1ns / 1ps

// channel  role        handshake              payload
// req      bin in      req_valid / req_ready  req (bin_index, time_ms, frame_number)
// res      level out   res_valid / res_ready  res (level, bin_echo, bin_valid)
// cfg      reg write   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// ten register stages; one word in and one out per cycle while res_ready is high
// the depth comes from the stage chain: reciprocal multiplies for the time
// modulos and the ramp division, and the multiplies of the noise hash
// each stage holds its word while the next is full and takes a new one into any
// bubble, so a word waiting at the output stops the input only once all ten stages are full
// synchronous reset clears the valid bits and loads the register defaults; cfg_ready is always high

module spectrum_test_pattern_bin_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  stpb_pkg::req_t                       req,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output stpb_pkg::res_t                       res,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [stpb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [stpb_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int N  = 10;
  localparam int LW = stpb_pkg::INT_LW;
  localparam int BW = stpb_pkg::BIN_W;
  localparam int CW = stpb_pkg::CNT_W;
  localparam int KW = $clog2(stpb_pkg::NOISE_SPREAD_DB * stpb_pkg::ONE_DB + 1);
  localparam logic [KW-1:0] NOISE_K = KW'(stpb_pkg::NOISE_SPREAD_DB * stpb_pkg::ONE_DB);

  // configuration registers
  logic [2:0]                            pattern_select;
  logic [CW-1:0]                         bin_count;
  logic signed [stpb_pkg::LEVEL_W-1:0]   min_level;
  logic signed [stpb_pkg::LEVEL_W-1:0]   max_level;
  logic [CW-1:0]                         signal_half_bins;
  logic [CW-1:0]                         tone_half_bins;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_select   <= stpb_pkg::PAT_FLOOR;
      bin_count        <= stpb_pkg::RST_BIN_COUNT;
      min_level        <= stpb_pkg::RST_MIN_LEVEL;
      max_level        <= stpb_pkg::RST_MAX_LEVEL;
      signal_half_bins <= '0;
      tone_half_bins   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        stpb_pkg::CFG_PATTERN_SELECT:   pattern_select   <= cfg_data[2:0];
        stpb_pkg::CFG_BIN_COUNT:        bin_count        <= cfg_data[CW-1:0];
        stpb_pkg::CFG_MIN_LEVEL:        min_level        <= signed'(cfg_data);
        stpb_pkg::CFG_MAX_LEVEL:        max_level        <= signed'(cfg_data);
        stpb_pkg::CFG_SIGNAL_HALF_BINS: signal_half_bins <= cfg_data[CW-1:0];
        stpb_pkg::CFG_TONE_HALF_BINS:   tone_half_bins   <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // values derived from the registers; not enforced: user keeps them steady while words are in flight
  logic [CW-1:0]          nb;
  logic [CW-1:0]          span;
  logic [CW-1:0]          comb_step;
  logic [CW-1:0]          comb_half;
  logic [CW-1:0]          centre;
  logic signed [16:0]     lvl_span;
  logic signed [LW-1:0]   floor_l;
  logic signed [LW-1:0]   sig_l;
  logic signed [LW-1:0]   min_w;
  logic signed [LW-1:0]   max_w;

  assign nb = (17'(bin_count) > 17'(stpb_pkg::MAX_BINS)) ? CW'(stpb_pkg::MAX_BINS)
                                                         : bin_count;
  assign span      = (nb == '0) ? '0 : nb - CW'(1);
  assign comb_step = (nb < CW'(stpb_pkg::COMB_LINES)) ? CW'(1)
                                                      : CW'(nb / stpb_pkg::COMB_LINES);
  assign comb_half = comb_step >> 1;
  assign centre    = nb >> 1;
  assign lvl_span  = 17'(max_level) - 17'(min_level);
  assign min_w     = LW'(min_level);
  assign max_w     = LW'(max_level);
  assign floor_l   = min_w + LW'(stpb_pkg::FLOOR_DB * stpb_pkg::ONE_DB);
  assign sig_l     = max_w - LW'(stpb_pkg::SIG_BACKOFF_DB * stpb_pkg::ONE_DB);

  // stage handshake: a stage loads when empty or when the next one loads
  logic [N:1]   v;
  logic [N+1:1] ld;

  always_comb begin
    ld[N+1] = res_ready;
    for (int i = N; i >= 1; i--) begin
      ld[i] = !v[i] || ld[i+1];
    end
  end

  assign req_ready = ld[1];
  assign res_valid = v[N];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[1]) v[1] <= req_valid;
      for (int i = 2; i <= N; i++) begin
        if (ld[i]) v[i] <= v[i-1];
      end
    end
  end

  // bin index travels with its word
  logic [BW-1:0] bin_s [1:N];

  always_ff @(posedge clk) begin
    if (ld[1]) bin_s[1] <= req.bin_index;
    for (int i = 2; i <= N; i++) begin
      if (ld[i]) bin_s[i] <= bin_s[i-1];
    end
  end

  // time modulos, stages 1 to 3
  logic [13:0] m10;
  logic [12:0] m8;

  stpb_divc #(.IN_W(stpb_pkg::TIME_W), .DIV(stpb_pkg::RAMP_MS)) u_div_ramp_t (
    .clk (clk),
    .en  (ld[3:1]),
    .x   (req.time_ms),
    .q   (),
    .r   (m10)
  );

  stpb_divc #(.IN_W(stpb_pkg::TIME_W), .DIV(stpb_pkg::SWEEP_MS)) u_div_sweep_t (
    .clk (clk),
    .en  (ld[3:1]),
    .x   (req.time_ms),
    .q   (),
    .r   (m8)
  );

  // noise hash, stages 1 to 5
  logic [31:0]          key1;
  logic [31:0]          n1;
  logic [31:0]          n2;
  logic [31:0]          n3;
  logic [31:0]          n3_s2;
  logic [31:0]          n4_s3;
  logic [31:0]          n5;
  logic [32+KW-1:0]     hp_s4;
  logic [KW-1:0]        h_hi;
  logic                 h_lo_zero;
  logic signed [LW-1:0] noise_fl;
  logic signed [LW-1:0] noise_s [5:8];

  assign n1 = (key1 ^ stpb_pkg::MIX_XOR) ^ (key1 >> 16);
  assign n2 = n1 + (n1 << 3);
  assign n3 = n2 ^ (n2 >> 4);
  assign n5 = n4_s3 ^ (n4_s3 >> 15);
  assign h_hi      = hp_s4[32 +: KW];
  assign h_lo_zero = (hp_s4[31:0] == '0);
  assign noise_fl  = sig_l - LW'(h_hi) - LW'(!h_lo_zero);

  always_ff @(posedge clk) begin
    if (ld[1]) key1  <= req.frame_number * stpb_pkg::HASH_SEED_MUL + 32'(req.bin_index);
    if (ld[2]) n3_s2 <= n3;
    if (ld[3]) n4_s3 <= n3_s2 * stpb_pkg::MIX_MUL;
    if (ld[4]) hp_s4 <= n5 * NOISE_K;
    // truncate toward zero: round the floor up when negative and inexact
    if (ld[5]) noise_s[5] <= (!noise_fl[LW-1] || h_lo_zero) ? noise_fl : noise_fl + LW'(1);
    for (int i = 6; i <= 8; i++) begin
      if (ld[i]) noise_s[i] <= noise_s[i-1];
    end
  end

  // ramp: product, numerator magnitude, then divide in stages 6 to 8
  logic signed [31:0] rprod_s4;
  logic signed [31:0] ramp_num;
  logic [28:0]        ramp_abs_s5;
  logic               ramp_neg_s [5:8];
  logic [15:0]        ramp_q;

  assign ramp_num = 32'(min_level) * 32'(stpb_pkg::RAMP_MS) + rprod_s4;

  always_ff @(posedge clk) begin
    if (ld[4]) rprod_s4 <= 32'(signed'({1'b0, m10})) * 32'(lvl_span);
    if (ld[5]) begin
      ramp_abs_s5   <= ramp_num[31] ? 29'(-ramp_num) : 29'(ramp_num);
      ramp_neg_s[5] <= ramp_num[31];
    end
    for (int i = 6; i <= 8; i++) begin
      if (ld[i]) ramp_neg_s[i] <= ramp_neg_s[i-1];
    end
  end

  stpb_divc #(.IN_W(29), .DIV(stpb_pkg::RAMP_MS)) u_div_ramp (
    .clk (clk),
    .en  (ld[8:6]),
    .x   (ramp_abs_s5),
    .q   (ramp_q),
    .r   ()
  );

  // swept carrier centre: product at stage 4, divide in stages 5 to 7
  logic [25:0] sprod_s4;
  logic [13:0] sweep_c;

  always_ff @(posedge clk) begin
    if (ld[4]) sprod_s4 <= 26'(m8) * 26'(span);
  end

  stpb_divc #(.IN_W(26), .DIV(stpb_pkg::SWEEP_MS)) u_div_sweep (
    .clk (clk),
    .en  (ld[7:5]),
    .x   (sprod_s4),
    .q   (sweep_c),
    .r   ()
  );

  // calibration tone bins k*B/5, stages 5 to 7
  logic [12:0] cal_c [stpb_pkg::CAL_LINES];

  for (genvar g = 0; g < stpb_pkg::CAL_LINES; g++) begin : g_cal
    stpb_divc #(.IN_W(15), .DIV(5)) u_div_cal (
      .clk (clk),
      .en  (ld[7:5]),
      .x   (15'(g + 1) * 15'(nb)),
      .q   (cal_c[g]),
      .r   ()
    );
  end

  // stage 8: hit flags
  logic signed [15:0] b7;
  logic signed [15:0] sw_c;
  logic signed [15:0] sw_h;
  logic               sweep_hit_s8;
  logic               comb_hit;
  logic               comb_hit_s8;
  logic [stpb_pkg::CAL_LINES-1:0] cal_hit_s8;

  assign b7   = signed'(16'(bin_s[7]));
  assign sw_c = signed'(16'(sweep_c));
  assign sw_h = signed'(16'(signal_half_bins));

  // comb lines at half + k*step; sixteen candidates cover every valid bin
  always_comb begin
    comb_hit = 1'b0;
    for (int k = 0; k < 16; k++) begin
      if (17'(bin_s[7]) == 17'(comb_half) + 17'(k) * 17'(comb_step)) comb_hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[8]) begin
      sweep_hit_s8 <= (b7 >= sw_c - sw_h) && (b7 <= sw_c + sw_h);
      comb_hit_s8  <= comb_hit;
      for (int k = 0; k < stpb_pkg::CAL_LINES; k++) begin
        cal_hit_s8[k] <= (16'(bin_s[7]) + 16'd1 >= 16'(cal_c[k])) &&
                         (16'(bin_s[7]) <= 16'(cal_c[k]) + 16'd1);
      end
    end
  end

  // stage 9: pattern select
  logic signed [15:0]   b8;
  logic signed [15:0]   ctr;
  logic signed [15:0]   th;
  logic signed [15:0]   sh;
  logic                 two_hit;
  logic                 noise_hit;
  logic signed [LW-1:0] ramp_v;
  logic signed [LW-1:0] cal_v;
  logic signed [LW-1:0] lvl_next;
  logic signed [LW-1:0] lvl_s9;
  logic                 valid_s9;

  assign b8  = signed'(16'(bin_s[8]));
  assign ctr = signed'(16'(centre));
  assign th  = signed'(16'(tone_half_bins));
  assign sh  = signed'(16'(signal_half_bins));
  assign two_hit   = (b8 == ctr - th) || (b8 == ctr + th);
  assign noise_hit = (b8 >= ctr - sh) && (b8 <= ctr + sh);
  assign ramp_v    = ramp_neg_s[8] ? -signed'(LW'(ramp_q)) : signed'(LW'(ramp_q));

  // highest covering tone against the floor
  always_comb begin
    cal_v = floor_l;
    for (int k = 0; k < stpb_pkg::CAL_LINES; k++) begin
      if (cal_hit_s8[k] &&
          LW'((stpb_pkg::CAL_BASE_DB + stpb_pkg::CAL_STEP_DB * (k + 1)) * stpb_pkg::ONE_DB)
          > cal_v) begin
        cal_v = LW'((stpb_pkg::CAL_BASE_DB + stpb_pkg::CAL_STEP_DB * (k + 1)) *
                    stpb_pkg::ONE_DB);
      end
    end
  end

  always_comb begin
    case (pattern_select)
      stpb_pkg::PAT_RAMP:  lvl_next = ramp_v;
      stpb_pkg::PAT_CAL:   lvl_next = cal_v;
      stpb_pkg::PAT_SWEPT: lvl_next = sweep_hit_s8 ? sig_l : floor_l;
      stpb_pkg::PAT_TWO:   lvl_next = two_hit ? sig_l : floor_l;
      stpb_pkg::PAT_COMB:  lvl_next = comb_hit_s8
                                      ? sig_l - LW'(stpb_pkg::COMB_DROP_DB * stpb_pkg::ONE_DB)
                                      : floor_l;
      stpb_pkg::PAT_NOISE: lvl_next = noise_hit ? noise_s[8] : floor_l;
      default:             lvl_next = floor_l;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[9]) begin
      lvl_s9   <= lvl_next;
      valid_s9 <= (CW'(bin_s[8]) < nb);
    end
  end

  // stage 10: clamp, lower bound first
  logic signed [LW-1:0]                clamp_lo;
  logic signed [LW-1:0]                clamp_v;
  logic signed [stpb_pkg::LEVEL_W-1:0] level_s10;
  logic                                valid_s10;

  assign clamp_lo = (lvl_s9 < min_w) ? min_w : lvl_s9;
  assign clamp_v  = (clamp_lo > max_w) ? max_w : clamp_lo;

  always_ff @(posedge clk) begin
    if (ld[10]) begin
      level_s10 <= valid_s9 ? clamp_v[stpb_pkg::LEVEL_W-1:0] : '0;
      valid_s10 <= valid_s9;
    end
  end

  assign res = {level_s10, bin_s[N], valid_s10};

`ifndef ASSERT_OFF
  // a full pipe with a stalled output takes no new word
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (&v) && !res_ready |-> !req_ready)
    else $error("word accepted into a full stalled pipe");

  // an accepted word lands in the first stage
  a_entry: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> v[1] && (bin_s[1] == $past(req.bin_index)))
    else $error("accepted word not captured in first stage");

  // a bin outside the frame reports level zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.bin_valid |-> res.level == '0)
    else $error("invalid bin with non-zero level");
`endif

endmodule

// ===== tb/stpb_level_checker.sv =====
`timescale 1ns / 1ps

module stpb_level_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  input  logic                                 req_ready,
  input  stpb_pkg::req_t                       req,
  input  logic                                 res_valid,
  input  logic                                 res_ready,
  input  stpb_pkg::res_t                       res,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [stpb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [stpb_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                   mismatches,
  output int                                   outstanding,
  output int                                   words_checked
);

  // level arithmetic in 1/16 dB steps
  localparam longint DB           = 16;
  localparam longint RAMP_PERIOD  = 10000;
  localparam longint SWEEP_PERIOD = 8000;
  localparam longint BIN_LIMIT    = 4096;
  localparam longint TWO_POW_32   = 64'sh1_0000_0000;

  // register copy, as the block should hold it
  logic [2:0] pat_r;
  longint     count_r;
  longint     lo_r;
  longint     hi_r;
  longint     sig_half_r;
  longint     tone_half_r;

  stpb_pkg::res_t levels_due[$];

  function automatic bit near(longint x, longint c, longint half);
    return x >= c - half && x <= c + half;
  endfunction

  // 32-bit integer scramble used to spread the noise band
  function automatic logic [31:0] scramble(logic [31:0] n);
    n = (n ^ 32'd61) ^ (n >> 16);
    n = n + (n << 3);
    n = n ^ (n >> 4);
    n = n * 32'h27d4eb2d;
    n = n ^ (n >> 15);
    return n;
  endfunction

  // level of one valid bin under the current pattern, clamped to the range
  function automatic longint spectrum_level(longint b, longint nb, logic [31:0] t,
                                            logic [31:0] frame);
    longint     floor_lv;
    longint     sig_lv;
    longint     v;
    longint     c;
    longint     lv;
    longint     m;
    longint     step;
    longint     d;
    logic [31:0] key;
    floor_lv = lo_r + 10 * DB;
    sig_lv   = hi_r - 5 * DB;
    v        = floor_lv;
    case (pat_r)
      stpb_pkg::PAT_RAMP: begin
        m = {32'd0, t} % RAMP_PERIOD;
        v = (lo_r * RAMP_PERIOD + m * (hi_r - lo_r)) / RAMP_PERIOD;
      end
      stpb_pkg::PAT_CAL: begin
        for (longint k = 1; k <= 4; k++) begin
          c  = (k * nb) / 5;
          lv = (-120 + 20 * k) * DB;
          if (near(b, c, 1) && lv > v) v = lv;
        end
      end
      stpb_pkg::PAT_SWEPT: begin
        m = {32'd0, t} % SWEEP_PERIOD;
        c = (m * (nb - 1)) / SWEEP_PERIOD;
        if (near(b, c, sig_half_r)) v = sig_lv;
      end
      stpb_pkg::PAT_TWO: begin
        c = nb / 2;
        if (b == c - tone_half_r || b == c + tone_half_r) v = sig_lv;
      end
      stpb_pkg::PAT_COMB: begin
        step = nb / 8;
        if (step < 1) step = 1;
        if (b >= step / 2 && (b - step / 2) % step == 0) v = sig_lv - 10 * DB;
      end
      stpb_pkg::PAT_NOISE: begin
        if (near(b, nb / 2, sig_half_r)) begin
          key = frame * 32'd1000003 + b[31:0];
          d   = {32'd0, scramble(key)};
          d   = d * 12 * DB;
          v   = (sig_lv * TWO_POW_32 - d) / TWO_POW_32;
        end
      end
      default: begin
      end
    endcase
    // lower bound first, so an inverted range gives the top
    if (v < lo_r) v = lo_r;
    if (v > hi_r) v = hi_r;
    return v;
  endfunction

  function automatic stpb_pkg::res_t bin_result(stpb_pkg::req_t w);
    stpb_pkg::res_t r;
    longint         nb;
    longint         b;
    nb = (count_r > BIN_LIMIT) ? BIN_LIMIT : count_r;
    b  = longint'(w.bin_index);
    r.bin_echo  = w.bin_index;
    r.bin_valid = (b < nb);
    r.level     = r.bin_valid ? 16'(spectrum_level(b, nb, w.time_ms, w.frame_number)) : '0;
    return r;
  endfunction

  // follow register writes, predict each request word, check each result word
  always @(posedge clk) begin
    stpb_pkg::res_t want;
    if (rst) begin
      pat_r       = stpb_pkg::PAT_FLOOR;
      count_r     = 1024;
      lo_r        = -2240;
      hi_r        = 0;
      sig_half_r  = 0;
      tone_half_r = 0;
      levels_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          stpb_pkg::CFG_PATTERN_SELECT:   pat_r       = cfg_data[2:0];
          stpb_pkg::CFG_BIN_COUNT:        count_r     = longint'(cfg_data[12:0]);
          stpb_pkg::CFG_MIN_LEVEL:        lo_r        = longint'($signed(cfg_data));
          stpb_pkg::CFG_MAX_LEVEL:        hi_r        = longint'($signed(cfg_data));
          stpb_pkg::CFG_SIGNAL_HALF_BINS: sig_half_r  = longint'(cfg_data[12:0]);
          stpb_pkg::CFG_TONE_HALF_BINS:   tone_half_r = longint'(cfg_data[12:0]);
          default: begin
          end
        endcase
      end
      if (req_valid && req_ready) levels_due.push_back(bin_result(req));
      if (res_valid && res_ready) begin
        if (levels_due.size() == 0) begin
          $error("result word for bin %0d with nothing expected", res.bin_echo);
          mismatches++;
        end else begin
          want = levels_due.pop_front();
          if (res.level !== want.level) begin
            $error("level: expected %0d, got %0d", want.level, res.level);
            mismatches++;
          end
          if (res.bin_echo !== want.bin_echo) begin
            $error("bin_echo: expected %0d, got %0d", want.bin_echo, res.bin_echo);
            mismatches++;
          end
          if (res.bin_valid !== want.bin_valid) begin
            $error("bin_valid: expected %0b, got %0b", want.bin_valid, res.bin_valid);
            mismatches++;
          end
          words_checked++;
        end
      end
    end
    outstanding = levels_due.size();
  end

endmodule

// ===== tb/tb_spectrum_test_pattern_bin_core.sv =====
`timescale 1ns / 1ps

module tb_spectrum_test_pattern_bin_core;

  localparam int STALL_PCT    = 35;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASES       = 13;
  localparam int PHASE_WORDS  = 50;

  logic                            clk;
  logic                            rst;
  logic                            req_valid;
  logic                            req_ready;
  stpb_pkg::req_t                  req;
  logic                            res_valid;
  logic                            res_ready;
  stpb_pkg::res_t                  res;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [stpb_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [stpb_pkg::CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int outstanding;
  int words_checked;
  int settings;
  int quiet_cycles;
  bit steady;

  // what was last written, used only to aim bins at the interesting spots
  logic [2:0] pat_sh;
  int         count_eff;
  int         sig_half_sh;
  int         tone_half_sh;

  spectrum_test_pattern_bin_core uut (
    .clk, .rst,
    .req_valid, .req_ready, .req,
    .res_valid, .res_ready, .res,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  stpb_level_checker checker_i (
    .clk, .rst,
    .req_valid, .req_ready, .req,
    .res_valid, .res_ready, .res,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .outstanding, .words_checked
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // result side back-pressure
  always @(negedge clk) begin
    res_ready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
  end

  // give up when no word moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (res_valid && res_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_spectrum_test_pattern_bin_core: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // wait until every predicted word has come back
  task automatic settle();
    while (outstanding != 0) @(negedge clk);
  endtask

  // one register write; valid is left high for a following write
  task automatic write_reg(input logic [stpb_pkg::CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(input int pat_word, input int cnt_word, input int lo, input int hi,
                           input int sig_word, input int tone_word);
    settle();
    write_reg(stpb_pkg::CFG_PATTERN_SELECT, pat_word);
    write_reg(stpb_pkg::CFG_BIN_COUNT, cnt_word);
    write_reg(stpb_pkg::CFG_MIN_LEVEL, lo);
    write_reg(stpb_pkg::CFG_MAX_LEVEL, hi);
    write_reg(stpb_pkg::CFG_SIGNAL_HALF_BINS, sig_word);
    write_reg(stpb_pkg::CFG_TONE_HALF_BINS, tone_word);
    cfg_valid <= 1'b0;
    pat_sh       = 3'(pat_word);
    count_eff    = cnt_word & 32'h1fff;
    if (count_eff > stpb_pkg::MAX_BINS) count_eff = stpb_pkg::MAX_BINS;
    sig_half_sh  = sig_word & 32'h1fff;
    tone_half_sh = tone_word & 32'h1fff;
    settings++;
  endtask

  // one request word, with random idle cycles ahead of it
  task automatic send_word(input logic [stpb_pkg::BIN_W-1:0] bin, input logic [31:0] t,
                           input logic [31:0] frame);
    stpb_pkg::req_t w;
    w.bin_index    = bin;
    w.time_ms      = t;
    w.frame_number = frame;
    while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // bin choice: mostly in frame, often right on a tone, line or band edge
  function automatic logic [stpb_pkg::BIN_W-1:0] aimed_bin(input logic [31:0] t);
    int nb;
    int c;
    int spread;
    int step;
    int pick;
    nb     = count_eff;
    pick   = $urandom_range(0, 9);
    spread = 1;
    if (pick < 2 || nb == 0) return 12'($urandom);
    if (pick < 5) return 12'($urandom_range(0, nb - 1));
    case (pat_sh)
      stpb_pkg::PAT_CAL:   c = (int'($urandom_range(1, 4)) * nb) / 5;
      stpb_pkg::PAT_SWEPT: begin
        c      = int'(t % 32'd8000) * (nb - 1) / 8000;
        spread = sig_half_sh + 1;
      end
      stpb_pkg::PAT_TWO:   c = nb / 2 + ($urandom_range(0, 1) ? tone_half_sh : -tone_half_sh);
      stpb_pkg::PAT_COMB: begin
        step = (nb / 8 < 1) ? 1 : nb / 8;
        c    = step / 2 + int'($urandom_range(0, 7)) * step;
      end
      stpb_pkg::PAT_NOISE: begin
        c      = nb / 2;
        spread = sig_half_sh + 1;
      end
      default:   c = $urandom_range(0, 1) ? 0 : nb - 1;
    endcase
    c = c + int'($urandom_range(0, 2 * spread)) - spread;
    if (c < 0 || c > 4095) c = $urandom_range(0, nb - 1);
    return 12'(c);
  endfunction

  initial begin
    int          pat_word;
    int          cnt;
    int          lo;
    int          hi;
    int          sig_word;
    int          tone_word;
    logic [31:0] t;
    logic [31:0] frame;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    res_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    steady    = 1'b0;
    pat_sh    = stpb_pkg::PAT_FLOOR;
    count_eff = 1024;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: flat floor, frame edge and bins past the frame
    send_word(12'd0, 32'd0, 32'd0);
    send_word(12'd1023, 32'hffffffff, 32'hffffffff);
    send_word(12'd1024, 32'd5000, 32'd1);
    send_word(12'd4095, 32'd0, 32'hffffffff);
    req_valid <= 1'b0;

    // ramp across the full level range, start, end and wrap of the period
    configure(stpb_pkg::PAT_RAMP, 64, -32768, 32767, 0, 0);
    send_word(12'd0, 32'd0, 32'd0);
    send_word(12'd63, 32'd9999, 32'd0);
    send_word(12'd7, 32'hffffffff, 32'd0);
    req_valid <= 1'b0;

    // calibration tones over the largest frame, on and beside tone bins
    configure(stpb_pkg::PAT_CAL, 4096, -2240, 0, 0, 0);
    send_word(12'd818, 32'd0, 32'd0);
    send_word(12'd819, 32'd0, 32'd0);
    send_word(12'd2458, 32'd0, 32'd0);
    send_word(12'd3277, 32'd0, 32'd0);
    req_valid <= 1'b0;

    // sweep with an oversized bin count, which saturates
    configure(stpb_pkg::PAT_SWEPT, 8191, -2240, 0, 2, 0);
    send_word(12'd2049, 32'd4000, 32'd0);
    send_word(12'd2050, 32'd4000, 32'd0);
    req_valid <= 1'b0;

    // two tone lines and a bin next to one
    configure(stpb_pkg::PAT_TWO, 1000, -2240, 0, 0, 100);
    send_word(12'd400, 32'd0, 32'd0);
    send_word(12'd600, 32'd0, 32'd0);
    send_word(12'd401, 32'd0, 32'd0);
    req_valid <= 1'b0;

    // comb with fewer bins than lines, so every bin is a line
    configure(stpb_pkg::PAT_COMB, 7, -2240, 0, 0, 0);
    send_word(12'd0, 32'd0, 32'd0);
    send_word(12'd6, 32'd0, 32'd0);
    send_word(12'd7, 32'd0, 32'd0);
    req_valid <= 1'b0;

    // noise band over the whole frame, frame number extremes
    configure(stpb_pkg::PAT_NOISE, 4096, -32768, 32767, 4096, 0);
    send_word(12'd0, 32'd0, 32'd0);
    send_word(12'd2048, 32'd0, 32'hffffffff);
    send_word(12'd4095, 32'd0, $urandom);
    req_valid <= 1'b0;

    // spare pattern code with an inverted range, first with zero bins, then with sixteen
    configure(stpb_pkg::PAT_SPARE, 0, 100, -100, 0, 0);
    send_word(12'd0, 32'd0, 32'd0);
    req_valid <= 1'b0;
    configure(stpb_pkg::PAT_SPARE, 16, 100, -100, 0, 0);
    send_word(12'd5, 32'd0, 32'd0);
    req_valid <= 1'b0;

    // random settings, one pattern after another, then any
    for (int ph = 0; ph < PHASES; ph++) begin
      pat_word = (ph < 8) ? ph : int'($urandom_range(0, 7));
      pat_word = pat_word | (int'($urandom_range(0, 8191)) << 3);
      case ($urandom_range(0, 5))
        0:       cnt = $urandom_range(0, 16);
        1:       cnt = $urandom_range(17, 4096);
        2:       cnt = $urandom_range(4097, 8191);
        3:       cnt = 4096;
        default: cnt = $urandom_range(8, 300);
      endcase
      cnt = cnt | (int'($urandom_range(0, 7)) << 13);
      if ($urandom_range(0, 3) == 0) begin
        lo = int'($urandom_range(0, 65535)) - 32768;
        hi = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        lo = -3000 + int'($urandom_range(0, 2000));
        hi = -400 + int'($urandom_range(0, 800));
      end
      sig_word  = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 65535)) :
                  int'($urandom_range(0, 12));
      tone_word = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 65535)) :
                  int'($urandom_range(0, 520));
      configure(pat_word, cnt, lo, hi, sig_word, tone_word);
      steady = (ph == 3);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // hold the sender until the pipe has drained completely
        if (ph == 6 && n == PHASE_WORDS / 2) begin
          req_valid <= 1'b0;
          settle();
          @(negedge clk);
        end
        t     = $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 20000)) : $urandom;
        frame = $urandom;
        send_word(aimed_bin(t), t, frame);
      end
      req_valid <= 1'b0;
      steady = 1'b0;
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("checked %0d result words across %0d register settings", words_checked, settings);
    $display("all pattern codes, frame edges, saturation and inverted ranges exercised");
    if (mismatches == 0) begin
      $display("tb_spectrum_test_pattern_bin_core: clean");
    end else begin
      $display("tb_spectrum_test_pattern_bin_core: errors");
    end
    $finish;
  end

endmodule
